### design/wsrl_pkg.sv
// shared constants and codes for the windowed send rate limiter
// no dependencies; imported by windowed_send_rate_limiter, wsrl_checker and the testbench
package wsrl_pkg;

    localparam int WINDOW_DEF   = 10;
    localparam int RATE_W       = 20;
    localparam int SIZE_W       = 16;
    localparam int TIME_W       = 32;
    localparam int CNT_W        = 32;
    localparam int SPACE_W      = 26;
    localparam int ALU_W        = 33;
    localparam int MOD_STEPS    = 2;

    typedef enum logic [1:0] {
        FN_CHECK  = 2'd0,
        FN_RECORD = 2'd1,
        FN_GATE   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

endpackage

### design/windowed_send_rate_limiter.sv
// windowed send rate limiter: ring of sent sizes, drop counter, send spacing
// uses wsrl_pkg for widths and function codes
//
//  channel  direction  handshake                    payload
//  in       to block   i_in_valid / o_in_stall      i_func i_frame_number i_now_ms i_sent_bytes
//  out      from block o_out_valid / i_out_stall    o_drop_frame o_may_send
//                                                   o_suppressed_total o_spacing_ms
//  cfg      to block   i_cfg_valid / o_cfg_ready    i_cfg_byte_rate
//
// one transaction at a time; a frame check is paced by the window sweep through the shared
// add/sub unit; a record by the 26-step divider on the same unit; the ring slot comes from
// a reciprocal multiply, a quotient step and then a remainder step
// a gate query is a subtract then a compare; a check or record with rate 0, or an unused code, goes straight to finish
// synchronous active-low reset clears rate, counters, ring valid bits and control
// a finished result waits in the output register while the next transaction is taken
module windowed_send_rate_limiter
    import wsrl_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [TIME_W-1:0]  i_frame_number,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [SIZE_W-1:0]  i_sent_bytes,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_drop_frame,
    output logic               o_may_send,
    output logic [CNT_W-1:0]   o_suppressed_total,
    output logic [SPACE_W-1:0] o_spacing_ms,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [RATE_W-1:0]  i_cfg_byte_rate
);

    // ceil(2^(TIME_W + sh) / w), exact quotient for every frame number
    function automatic logic [TIME_W:0] recip_of(input int w, input int sh);
        logic [71:0] num;
        num = 72'(1) << (TIME_W + sh);
        return (TIME_W + 1)'((num + 72'(w - 1)) / 72'(w));
    endfunction

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [IW:0]   WIN_V    = (IW + 1)'(WINDOW);
    localparam logic [IW-1:0] WIN_LAST = IW'(WINDOW - 1);
    localparam int RSH = $clog2(WINDOW);
    localparam logic [TIME_W:0] RECIP = recip_of(WINDOW, RSH);
    localparam int MCW = $clog2(MOD_STEPS + 1);
    localparam logic [MCW-1:0] MOD_START = MCW'(MOD_STEPS);
    localparam int DCW = $clog2(SPACE_W);
    localparam logic [DCW-1:0] DIV_LAST = DCW'(SPACE_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_SUM_END,
        S_CMP,
        S_DIV,
        S_ELAP,
        S_GATE,
        S_SLOT,
        S_FIN
    } t_state;

    t_state               r_state;
    t_func                r_func;
    logic [RATE_W-1:0]    r_rate;
    logic [TIME_W-1:0]    r_last;
    logic [SPACE_W-1:0]   r_spacing;
    logic [CNT_W-1:0]     r_drop_cnt;
    logic [TIME_W-1:0]    r_now;
    logic [SIZE_W-1:0]    r_size;
    logic [TIME_W-1:0]    r_frame;
    logic [MCW-1:0]       r_mod_cnt;
    logic [IW-1:0]        r_quo;
    logic [IW-1:0]        r_mod;
    logic [IW-1:0]        r_idx;
    logic                 r_rd_live;
    logic                 r_rd_vld;
    logic [SIZE_W-1:0]    r_rd_data;
    logic [TIME_W-1:0]    r_acc;
    logic [RATE_W-1:0]    r_rem;
    logic [SPACE_W-1:0]   r_dvd;
    logic [DCW-1:0]       r_dcnt;
    logic                 r_drop;
    logic                 r_may;
    logic [WINDOW-1:0]    r_vld;
    logic [SIZE_W-1:0]    r_ring [WINDOW];
    logic                 r_out_valid;
    logic                 r_o_drop;
    logic                 r_o_may;
    logic [CNT_W-1:0]     r_o_total;
    logic [SPACE_W-1:0]   r_o_spacing;

    logic [ALU_W-1:0]     alu_a;
    logic [ALU_W-1:0]     alu_b;
    logic                 alu_sub;
    logic [ALU_W-1:0]     alu_res;
    logic                 alu_borrow;
    logic [2*TIME_W:0]    mod_prod;
    logic [2*IW:0]        quo_w;
    logic                 mod_done;
    logic [RATE_W:0]      rem_sh;
    logic [SPACE_W-1:0]   size_k;
    logic                 in_acc;
    logic                 out_free;
    logic                 ring_we;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign mod_done = (r_mod_cnt == '0);
    assign ring_we  = (r_state == S_SLOT) && mod_done && (r_func == FN_RECORD);

    // ring slot: quotient by reciprocal multiply, remainder from its low bits
    assign mod_prod = (2*TIME_W+1)'(r_frame) * (2*TIME_W+1)'(RECIP);
    assign quo_w    = (2*IW+1)'(r_quo) * (2*IW+1)'(WIN_V);

    // size * 1000 as shifts
    assign size_k = (SPACE_W'(i_sent_bytes) << 10) - (SPACE_W'(i_sent_bytes) << 4)
                  - (SPACE_W'(i_sent_bytes) << 3);

    assign rem_sh = {r_rem, r_dvd[SPACE_W-1]};

    // shared add/sub unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (r_state)
            S_SUM, S_SUM_END: begin
                alu_a = ALU_W'(r_acc);
                alu_b = r_rd_vld ? ALU_W'(r_rd_data) : '0;
            end
            S_CMP: begin
                alu_a   = ALU_W'(r_rate);
                alu_b   = ALU_W'(r_acc);
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = ALU_W'(rem_sh);
                alu_b   = ALU_W'(r_rate);
                alu_sub = 1'b1;
            end
            S_ELAP: begin
                alu_a   = ALU_W'(r_now);
                alu_b   = ALU_W'(r_last);
                alu_sub = 1'b1;
            end
            S_GATE: begin
                alu_a   = ALU_W'(r_acc);
                alu_b   = ALU_W'(r_spacing);
                alu_sub = 1'b1;
            end
            S_SLOT: begin
                alu_a = ALU_W'(r_drop_cnt);
                alu_b = ALU_W'(1);
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    assign alu_res    = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
    assign alu_borrow = alu_res[ALU_W-1];

    // ring storage
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_mod] <= r_size;
        end
        r_rd_data <= r_ring[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_func      <= FN_NONE;
            r_rate      <= '0;
            r_last      <= '0;
            r_spacing   <= '0;
            r_drop_cnt  <= '0;
            r_mod_cnt   <= '0;
            r_vld       <= '0;
            r_rd_live   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_drop      <= 1'b0;
            r_may       <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_drop    <= 1'b0;
            r_o_may     <= 1'b0;
            r_o_total   <= '0;
            r_o_spacing <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_rate <= i_cfg_byte_rate;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (!mod_done && !in_acc) begin
                if (r_mod_cnt == MOD_START) begin
                    r_quo <= mod_prod[TIME_W+RSH +: IW];
                end else begin
                    r_mod <= r_frame[IW-1:0] - quo_w[IW-1:0];
                end
                r_mod_cnt <= r_mod_cnt - MCW'(1);
            end
            r_rd_vld <= r_vld[r_idx];

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_func    <= t_func'(i_func);
                        r_frame   <= i_frame_number;
                        r_now     <= i_now_ms;
                        r_size    <= i_sent_bytes;
                        r_mod     <= '0;
                        r_mod_cnt <= MOD_START;
                        r_idx     <= '0;
                        r_acc     <= '0;
                        r_rd_live <= 1'b0;
                        r_drop    <= 1'b0;
                        r_may     <= 1'b0;
                        r_rem     <= '0;
                        r_dvd     <= size_k;
                        r_dcnt    <= '0;
                        case (t_func'(i_func))
                            FN_CHECK: begin
                                r_state <= (r_rate == '0) ? S_FIN : S_SUM;
                            end
                            FN_RECORD: begin
                                r_last <= i_now_ms;
                                if (r_rate == '0) begin
                                    r_spacing <= '0;
                                    r_state   <= S_FIN;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            FN_GATE: begin
                                r_state <= S_ELAP;
                            end
                            default: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SUM: begin
                    r_rd_live <= 1'b1;
                    if (r_rd_live) begin
                        r_acc <= alu_res[TIME_W-1:0];
                    end
                    if (r_idx == WIN_LAST) begin
                        r_state <= S_SUM_END;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_SUM_END: begin
                    r_acc   <= alu_res[TIME_W-1:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_drop  <= alu_borrow;
                    r_state <= S_SLOT;
                end
                S_DIV: begin
                    if (!alu_borrow) begin
                        r_rem <= alu_res[RATE_W-1:0];
                    end else begin
                        r_rem <= rem_sh[RATE_W-1:0];
                    end
                    r_dvd  <= {r_dvd[SPACE_W-2:0], !alu_borrow};
                    r_dcnt <= r_dcnt + DCW'(1);
                    if (r_dcnt == DIV_LAST) begin
                        r_state <= S_SLOT;
                    end
                end
                S_ELAP: begin
                    r_acc   <= alu_res[TIME_W-1:0];
                    r_state <= S_GATE;
                end
                S_GATE: begin
                    r_may   <= !alu_borrow;
                    r_state <= S_FIN;
                end
                S_SLOT: begin
                    if (mod_done) begin
                        if (r_func == FN_RECORD) begin
                            r_vld[r_mod] <= 1'b1;
                            r_spacing    <= r_dvd;
                        end else if (r_drop) begin
                            r_vld[r_mod] <= 1'b0;
                            r_drop_cnt   <= alu_res[CNT_W-1:0];
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_drop    <= r_drop && (r_func == FN_CHECK);
                        r_o_may     <= r_may && (r_func == FN_GATE);
                        r_o_total   <= r_drop_cnt;
                        r_o_spacing <= r_spacing;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_drop_frame       = r_o_drop;
    assign o_may_send         = r_o_may;
    assign o_suppressed_total = r_o_total;
    assign o_spacing_ms       = r_o_spacing;
    assign o_cfg_ready        = 1'b1;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("accepted transaction did not stall input");

    a_rem_below_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_rate))
        else $error("divider remainder out of range");

    a_slot_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT) && mod_done |-> (IW + 1)'(r_mod) < WIN_V)
        else $error("ring slot outside window");

    a_drop_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SLOT) && mod_done && (r_func == FN_CHECK) && r_drop
        |=> r_drop_cnt == $past(r_drop_cnt) + CNT_W'(1))
        else $error("drop not counted");

    a_no_drop_unlimited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) && (r_func == FN_CHECK) && (r_rate == '0) |-> !r_drop)
        else $error("drop reported with unlimited rate");
`endif

endmodule

### tb/sv/wsrl_checker.sv
// checker for the windowed send rate limiter: watches the in, out and cfg channels,
// predicts each result from its own copy of the limiter state and compares field by field
// depends on wsrl_pkg for widths and function codes
module wsrl_checker
    import wsrl_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_func,
    input  logic [TIME_W-1:0]  i_frame_number,
    input  logic [TIME_W-1:0]  i_now_ms,
    input  logic [SIZE_W-1:0]  i_sent_bytes,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_drop_frame,
    input  logic               i_may_send,
    input  logic [CNT_W-1:0]   i_suppressed_total,
    input  logic [SPACE_W-1:0] i_spacing_ms,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [RATE_W-1:0]  i_cfg_byte_rate,
    output int                 o_fail_count,
    output int                 o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_func              func;
        logic [TIME_W-1:0]  frame;
        logic [TIME_W-1:0]  now;
        logic [SIZE_W-1:0]  size;
    } t_link_op;

    typedef struct packed {
        logic               drop;
        logic               may;
        logic [CNT_W-1:0]   suppressed;
        logic [SPACE_W-1:0] spacing;
    } t_link_status;

    logic [SIZE_W-1:0]  sent_sizes [WINDOW];
    logic [TIME_W-1:0]  last_send_ms;
    logic [SPACE_W-1:0] gap_ms;
    logic [CNT_W-1:0]   drops;
    logic [RATE_W-1:0]  rate;
    t_link_status       predicted_status [$];
    int                 fails = 0;

    function automatic t_link_status apply_link_op(input t_link_op op);
        t_link_status st;
        logic [31:0]  total;
        logic [31:0]  slot;
        logic [31:0]  elapsed;
        logic [31:0]  product;
        st      = '0;
        total   = '0;
        slot    = op.frame % 32'(WINDOW);
        for (int i = 0; i < WINDOW; i++) begin
            total += 32'(sent_sizes[i]);
        end
        case (op.func)
            FN_CHECK: begin
                if (rate != '0 && total > 32'(rate)) begin
                    st.drop          = 1'b1;
                    drops            = drops + 1'b1;
                    sent_sizes[slot] = '0;
                end
            end
            FN_RECORD: begin
                last_send_ms = op.now;
                if (rate == '0) begin
                    gap_ms = '0;
                end else begin
                    sent_sizes[slot] = op.size;
                    product          = 32'(op.size) * 32'd1000;
                    gap_ms           = SPACE_W'(product / 32'(rate));
                end
            end
            FN_GATE: begin
                elapsed = op.now - last_send_ms;
                st.may  = (elapsed >= 32'(gap_ms));
            end
            default: begin
            end
        endcase
        st.suppressed = drops;
        st.spacing    = gap_ms;
        return st;
    endfunction

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
        fails++;
        $display("%0t ns mismatch on %s: expected %0h actual %0h", $time, field, want, seen);
    endtask

    always @(posedge i_clk) begin
        t_link_op     op;
        t_link_status got;
        t_link_status want;
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                sent_sizes[i] = '0;
            end
            last_send_ms = '0;
            gap_ms       = '0;
            drops        = '0;
            rate         = '0;
            predicted_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                rate = i_cfg_byte_rate;
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_drop_frame, i_may_send, i_suppressed_total, i_spacing_ms};
                if (predicted_status.size() == 0) begin
                    fails++;
                    $display("%0t ns unexpected result transaction: expected none actual %0h",
                             $time, got);
                end else begin
                    want = predicted_status.pop_front();
                    if (got.drop !== want.drop)
                        report_field("drop_frame", 32'(want.drop), 32'(got.drop));
                    if (got.may !== want.may)
                        report_field("may_send", 32'(want.may), 32'(got.may));
                    if (got.suppressed !== want.suppressed)
                        report_field("suppressed_total", want.suppressed, got.suppressed);
                    if (got.spacing !== want.spacing)
                        report_field("spacing_ms", 32'(want.spacing), 32'(got.spacing));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                op = '{t_func'(i_func), i_frame_number, i_now_ms, i_sent_bytes};
                predicted_status.push_back(apply_link_op(op));
            end
        end
        o_pending    <= predicted_status.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/windowed_send_rate_limiter_tb.sv
// top of the windowed send rate limiter testbench: clock, reset, stimulus and verdict
// drives directed and random transactions under several byte rates with random idling
// depends on wsrl_pkg, windowed_send_rate_limiter and wsrl_checker
module windowed_send_rate_limiter_tb;
    import wsrl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 3000;
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 230;
    localparam int PHASES       = 8;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = FN_CHECK;
    logic [TIME_W-1:0]  i_frame_number = '0;
    logic [TIME_W-1:0]  i_now_ms = '0;
    logic [SIZE_W-1:0]  i_sent_bytes = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_drop_frame;
    logic               o_may_send;
    logic [CNT_W-1:0]   o_suppressed_total;
    logic [SPACE_W-1:0] o_spacing_ms;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [RATE_W-1:0]  i_cfg_byte_rate = '0;

    int fail_count;
    int pending;
    bit calm = 1'b0;
    int hold_req = 0;

    windowed_send_rate_limiter u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_frame_number     (i_frame_number),
        .i_now_ms           (i_now_ms),
        .i_sent_bytes       (i_sent_bytes),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_drop_frame       (o_drop_frame),
        .o_may_send         (o_may_send),
        .o_suppressed_total (o_suppressed_total),
        .o_spacing_ms       (o_spacing_ms),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_byte_rate    (i_cfg_byte_rate)
    );

    wsrl_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_frame_number     (i_frame_number),
        .i_now_ms           (i_now_ms),
        .i_sent_bytes       (i_sent_bytes),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_drop_frame       (o_drop_frame),
        .i_may_send         (o_may_send),
        .i_suppressed_total (o_suppressed_total),
        .i_spacing_ms       (o_spacing_ms),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_byte_rate    (i_cfg_byte_rate),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm) return 0;
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_op(input t_func func, input logic [TIME_W-1:0] frame,
                           input logic [TIME_W-1:0] now, input logic [SIZE_W-1:0] size);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_func         <= func;
        i_frame_number <= frame;
        i_now_ms       <= now;
        i_sent_bytes   <= size;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_rate(input logic [RATE_W-1:0] value);
        drain();
        i_cfg_valid     <= 1'b1;
        i_cfg_byte_rate <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int count, input logic [RATE_W-1:0] rate,
                               input bit squeeze);
        logic [TIME_W-1:0] frame;
        logic [TIME_W-1:0] clock_ms;
        int                size_cap;
        int                roll;
        int                k;
        t_func             func;
        frame    = $urandom;
        clock_ms = $urandom;
        size_cap = (rate == '0 || rate > 300000) ? 65535 : int'(rate) / 5 + 1;
        for (k = 0; k < count; k++) begin
            if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            // long receiver hold-off while the sender keeps offering
            if (squeeze && k == count / 2) begin
                calm = 1'b1;
                hold_req++;
            end
            roll = $urandom_range(0, 99);
            if (roll < 85) begin
                frame    += $urandom_range(0, 1);
                clock_ms += $urandom_range(0, 120);
                roll = $urandom_range(0, 99);
                if (roll < 35)      func = FN_CHECK;
                else if (roll < 70) func = FN_RECORD;
                else if (roll < 96) func = FN_GATE;
                else                func = FN_NONE;
                send_op(func, frame, clock_ms, SIZE_W'($urandom_range(0, size_cap)));
            end else begin
                send_op(t_func'(2'($urandom_range(0, 3))), $urandom, $urandom,
                        SIZE_W'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    // receiver side
    initial begin
        int hold_done;
        int n;
        hold_done = 0;
        forever begin
            if (hold_req != hold_done) begin
                hold_done = hold_req;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        int idle;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle = 0;
        end else begin
            idle++;
        end
        if (idle >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [RATE_W-1:0] phase_rate [PHASES];
        int                k;
        phase_rate = '{20'd1, 20'hFFFFF, 20'd1000, 20'd0, 20'd50000, 20'd200000,
                       20'd655350, 20'd1};
        phase_rate[PHASES-1] = RATE_W'($urandom_range(2, 20000));
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // unlimited rate straight after reset
        send_op(FN_GATE, 32'd0, 32'd0, 16'd0);
        send_op(FN_CHECK, 32'd0, 32'd0, 16'd0);
        send_op(FN_RECORD, 32'd0, 32'hFFFF_FFF0, 16'hFFFF);
        send_op(FN_GATE, 32'hFFFF_FFFF, 32'd5, 16'hFFFF);
        send_op(FN_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);

        // lowest rate: largest spacing, drops and slot clearing
        set_rate(20'd1);
        send_op(FN_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(FN_GATE, 32'd0, 32'd0, 16'd0);
        send_op(FN_GATE, 32'd0, 32'd65534999, 16'd0);
        send_op(FN_CHECK, 32'd3, 32'd0, 16'd0);
        send_op(FN_CHECK, 32'd5, 32'd0, 16'd0);
        send_op(FN_CHECK, 32'd7, 32'd0, 16'd0);
        send_op(FN_RECORD, 32'd0, 32'd0, 16'd0);
        send_op(FN_RECORD, 32'd1, 32'd0, 16'd1);
        send_op(FN_NONE, 32'd0, 32'd0, 16'd0);

        // highest rate with a full ring of largest sizes
        set_rate(20'hFFFFF);
        for (k = 0; k < WINDOW_DEF; k++) begin
            send_op(FN_RECORD, 32'(k), 32'(k), 16'hFFFF);
        end
        send_op(FN_CHECK, 32'd0, 32'd20, 16'd0);

        for (k = 0; k < PHASES; k++) begin
            set_rate(phase_rate[k]);
            run_traffic(PHASE_ITEMS, phase_rate[k], k == 2);
        end

        drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
